/* rtl/rvq_pkg.sv */
// Shared types and constants for the rotated vector quantizer.
// Request/result structs, register indexes, command codes, centroid table.
// No dependencies.
package rvq_pkg;

  localparam int unsigned MaxDim   = 256;
  localparam int unsigned DimW     = 9;
  localparam int unsigned Lanes    = 4;
  localparam int unsigned NumMag   = 15;
  localparam int unsigned MagW     = 14;
  localparam int unsigned NumThr   = 15;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned Chunks   = 64;

  localparam logic CmdLoad     = 1'b0;
  localparam logic CmdQuantize = 1'b1;

  typedef enum logic [2:0] {
    RegDimension     = 3'd0,
    RegBitDepth      = 3'd1,
    RegRotationMode  = 3'd2,
    RegRotateEnable  = 3'd3,
    RegCentroidScale = 3'd4
  } reg_index_t;

  typedef logic [NumMag-1:0][MagW-1:0] mag_arr_t;

  // unit-normal Lloyd-Max magnitudes in Q3.12, grouped by depth 1, 2, 3, 4
  localparam mag_arr_t CentroidMag = {
    14'd11193, 14'd8475, 14'd6627, 14'd5145, 14'd3860, 14'd2690, 14'd1589, 14'd526,
    14'd8815, 14'd5505, 14'd3097, 14'd1004,
    14'd6185, 14'd1855,
    14'd3268
  };

  localparam logic signed [17:0] ThrNone = 18'sh0FFFF;

  typedef struct packed {
    logic                command;
    logic [5:0]          chunk_index;
    logic signed [15:0]  elem_0;
    logic signed [15:0]  elem_1;
    logic signed [15:0]  elem_2;
    logic signed [15:0]  elem_3;
    logic signed [15:0]  rot_0;
    logic signed [15:0]  rot_1;
    logic signed [15:0]  rot_2;
    logic signed [15:0]  rot_3;
  } req_t;

  typedef struct packed {
    logic [5:0] chunk_out;
    logic [3:0] code_0;
    logic [3:0] code_1;
    logic [3:0] code_2;
    logic [3:0] code_3;
    logic [2:0] valid_lanes;
  } res_t;

endpackage

/* rtl/rotated_vector_quantizer_core.sv */
// Rotated vector quantizer, top level: APB registers, rotation word memory,
// five-stage pipeline (input, products, rotate/saturate, thresholds, codes).
// Depends on rvq_pkg.
// Throughput: one request per cycle; a stage holds only while it and every
// stage after it are full and the result is stalled.
// Load requests write the 64-entry rotation memory and produce no result.
// Reset (rst, synchronous): registers to their reset values, pipeline emptied;
// the rotation memory is not cleared and a word must be loaded before use.
module rotated_vector_quantizer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [rvq_pkg::AddrW-1:0] paddr,
  input  logic [rvq_pkg::DataW-1:0] pwdata,
  output logic [rvq_pkg::DataW-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  rvq_pkg::req_t         req_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output rvq_pkg::res_t         res_data
);
  import rvq_pkg::*;

  // configuration
  logic [DimW-1:0] dimension;
  logic [2:0]      bit_depth;
  logic            rotation_mode;
  logic            rotate_enable;
  logic [15:0]     centroid_scale;
  logic            cfg_write;
  reg_index_t      cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension      <= DimW'(256);
      bit_depth      <= 3'd4;
      rotation_mode  <= 1'b0;
      rotate_enable  <= 1'b0;
      centroid_scale <= 16'd4096;
    end else if (cfg_write) begin
      case (cfg_index)
        RegDimension:     dimension      <= pwdata[DimW-1:0];
        RegBitDepth:      bit_depth      <= pwdata[2:0];
        RegRotationMode:  rotation_mode  <= pwdata[0];
        RegRotateEnable:  rotate_enable  <= pwdata[0];
        RegCentroidScale: centroid_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      RegDimension:     prdata = DataW'(dimension);
      RegBitDepth:      prdata = DataW'(bit_depth);
      RegRotationMode:  prdata = DataW'(rotation_mode);
      RegRotateEnable:  prdata = DataW'(rotate_enable);
      RegCentroidScale: prdata = DataW'(centroid_scale);
      default:          prdata = '0;
    endcase
  end

  // scaled codebook and decision thresholds, refreshed every cycle
  mag_arr_t         scaled_mag;
  logic signed [17:0] thr [NumThr];
  logic signed [17:0] thr_next [NumThr];
  logic signed [17:0] c_lo;
  logic signed [17:0] c_hi;
  logic [2:0]       depth_eff;
  logic [4:0]       half;
  logic [4:0]       ncent;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NumMag; i++) begin
      scaled_mag[i] <= MagW'((30'(CentroidMag[i]) * 30'(centroid_scale)) >> 16);
    end
  end

  function automatic logic signed [17:0] cent_val(input logic [4:0] i, input logic [4:0] h,
                                                 input mag_arr_t sm);
    logic [4:0] idx;
    begin
      if (i < h) begin
        idx = (h - 5'd1) + (h - 5'd1 - i);
        cent_val = -$signed({4'b0, sm[idx[3:0]]});
      end else begin
        idx = i - 5'd1;
        cent_val = $signed({4'b0, sm[idx[3:0]]});
      end
    end
  endfunction

  // equal neighbors never move the code up: lower index wins the tie
  always_comb begin
    if (bit_depth == 3'd0) begin
      depth_eff = 3'd1;
    end else if (bit_depth > 3'd4) begin
      depth_eff = 3'd4;
    end else begin
      depth_eff = bit_depth;
    end
    half  = 5'd1 << (depth_eff - 3'd1);
    ncent = half << 1;
    c_lo  = '0;
    c_hi  = '0;
    for (int k = 0; k < NumThr; k++) begin
      c_lo = cent_val(5'(k), half, scaled_mag);
      c_hi = cent_val(5'(k + 1), half, scaled_mag);
      if (5'(k) < ncent - 5'd1 && c_lo != c_hi) begin
        thr_next[k] = c_lo + c_hi;
      end else begin
        thr_next[k] = ThrNone;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumThr; k++) begin
      thr[k] <= thr_next[k];
    end
  end

  // pipeline enables
  logic s0_valid, s1_valid, s2_valid, s3_valid;
  logic s0_en, s1_en, s2_en, s3_en, s4_en;
  logic req_fire;

  assign s4_en     = !res_valid || !res_stall;
  assign s3_en     = !s3_valid || s4_en;
  assign s2_en     = !s2_valid || s3_en;
  assign s1_en     = !s1_valid || s2_en;
  assign s0_en     = !s0_valid || s1_en;
  assign req_stall = !s0_en;
  assign req_fire  = req_valid && s0_en;

  // rotation word memory
  logic [63:0] rot_mem [Chunks];
  logic [63:0] rot_rd;

  always_ff @(posedge clk) begin
    if (req_fire && req_data.command == CmdLoad) begin
      rot_mem[req_data.chunk_index] <= {req_data.rot_3, req_data.rot_2,
                                        req_data.rot_1, req_data.rot_0};
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      rot_rd <= rot_mem[req_data.chunk_index];
    end
  end

  // stage 0: lane count and masking
  logic [DimW-1:0]    dim_eff;
  logic [DimW-1:0]    base;
  logic [DimW-1:0]    remain;
  logic [2:0]         lanes_in;
  logic               in_range;
  logic signed [15:0] elem_in [Lanes];
  logic [5:0]         s0_chunk;
  logic [2:0]         s0_lanes;
  logic signed [15:0] s0_elem [Lanes];

  always_comb begin
    if (dimension == '0) begin
      dim_eff = DimW'(1);
    end else if (DimW'(dimension) > DimW'(MaxDim)) begin
      dim_eff = DimW'(MaxDim);
    end else begin
      dim_eff = dimension;
    end
    base     = DimW'({req_data.chunk_index, 2'b00});
    in_range = base < dim_eff;
    remain   = dim_eff - base;
    lanes_in = (remain > DimW'(4)) ? 3'd4 : remain[2:0];
    elem_in[0] = req_data.elem_0;
    elem_in[1] = req_data.elem_1;
    elem_in[2] = req_data.elem_2;
    elem_in[3] = req_data.elem_3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_en) begin
      s0_valid <= req_valid && req_data.command == CmdQuantize && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_chunk <= req_data.chunk_index;
      s0_lanes <= lanes_in;
      for (int j = 0; j < Lanes; j++) begin
        s0_elem[j] <= (3'(j) < lanes_in) ? elem_in[j] : 16'sd0;
      end
    end
  end

  // stage 1: all sixteen products
  logic signed [31:0] s1_prod [Lanes][Lanes];
  logic signed [15:0] s1_elem [Lanes];
  logic [5:0]         s1_chunk;
  logic [2:0]         s1_lanes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_chunk <= s0_chunk;
      s1_lanes <= s0_lanes;
      for (int i = 0; i < Lanes; i++) begin
        s1_elem[i] <= s0_elem[i];
        for (int j = 0; j < Lanes; j++) begin
          s1_prod[i][j] <= $signed(rot_rd[16*i +: 16]) * s0_elem[j];
        end
      end
    end
  end

  // stage 2: sum, floor shift, saturate; elements pass through unchanged when rotation is off
  function automatic logic signed [15:0] shift_sat(input logic signed [33:0] v);
    logic signed [19:0] r;
    begin
      r = 20'(v >>> 14);
      if (r > 20'sd32767) begin
        shift_sat = 16'sh7FFF;
      end else if (r < -20'sd32768) begin
        shift_sat = 16'sh8000;
      end else begin
        shift_sat = r[15:0];
      end
    end
  endfunction

  logic signed [33:0] p [Lanes][Lanes];
  logic signed [33:0] acc [Lanes];
  logic signed [15:0] y_next [Lanes];
  logic signed [15:0] s2_y [Lanes];
  logic [5:0]         s2_chunk;
  logic [2:0]         s2_lanes;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      for (int j = 0; j < Lanes; j++) begin
        p[i][j] = 34'(s1_prod[i][j]);
      end
    end
    if (rotation_mode) begin
      acc[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
      acc[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
      acc[2] = p[0][2] - p[1][3] + p[2][0] + p[3][1];
      acc[3] = p[0][3] + p[1][2] - p[2][1] + p[3][0];
    end else begin
      acc[0] = p[0][0] - p[1][1];
      acc[1] = p[1][0] + p[0][1];
      acc[2] = p[2][2] - p[3][3];
      acc[3] = p[3][2] + p[2][3];
    end
    for (int j = 0; j < Lanes; j++) begin
      y_next[j] = rotate_enable ? shift_sat(acc[j]) : s1_elem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_chunk <= s2_chunk_in();
      s2_lanes <= s1_lanes;
      for (int j = 0; j < Lanes; j++) begin
        s2_y[j] <= y_next[j];
      end
    end
  end

  function automatic logic [5:0] s2_chunk_in();
    return s1_chunk;
  endfunction

  // stage 3: compare against midpoints, one flag per decision point
  logic [Lanes-1:0][NumThr-1:0] s3_therm;
  logic [5:0]                   s3_chunk;
  logic [2:0]                   s3_lanes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_chunk <= s2_chunk;
      s3_lanes <= s2_lanes;
      for (int j = 0; j < Lanes; j++) begin
        for (int k = 0; k < NumThr; k++) begin
          s3_therm[j][k] <= $signed({s2_y[j][15], s2_y[j], 1'b0}) > thr[k];
        end
      end
    end
  end

  // stage 4: code is one past the highest set flag; hold result
  logic [3:0] code [Lanes];

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      code[j] = 4'd0;
      for (int k = 0; k < NumThr; k++) begin
        if (s3_therm[j][k]) code[j] = 4'(k + 1);
      end
      if (!(3'(j) < s3_lanes)) code[j] = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s4_en) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      res_data.chunk_out   <= s3_chunk;
      res_data.code_0      <= code[0];
      res_data.code_1      <= code[1];
      res_data.code_2      <= code[2];
      res_data.code_3      <= code[3];
      res_data.valid_lanes <= s3_lanes;
    end
  end

endmodule

/* rtl/rvq_checker.sv */
// Port-level checks for the rotated vector quantizer, bound to the top level.
// Depends on rvq_pkg and rotated_vector_quantizer_core.
module rvq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          res_valid,
  input logic          res_stall,
  input rvq_pkg::res_t res_data
);
  import rvq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.valid_lanes != 3'd0 && res_data.valid_lanes <= 3'd4)
    else $error("valid lane count out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.valid_lanes > 3'd1 || res_data.code_1 == 4'd0)
               && (res_data.valid_lanes > 3'd2 || res_data.code_2 == 4'd0)
               && (res_data.valid_lanes > 3'd3 || res_data.code_3 == 4'd0))
    else $error("padded lane has nonzero code");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with empty output");

endmodule

bind rotated_vector_quantizer_core rvq_checker u_rvq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

/* test/tb_rotated_vector_quantizer_core.sv */
// Testbench for rotated_vector_quantizer_core: random and directed load/quantize requests,
// APB register setup between phases, in-order result checking against a local predictor.
// Depends on rvq_pkg and the core RTL.
module tb_rotated_vector_quantizer_core;
  import rvq_pkg::*;

  localparam int HalfPeriod   = 10;
  localparam int HoldCycles   = 300;
  localparam int PhaseItems   = 250;
  localparam int RandomPhases = 8;
  localparam int SettleCycles = 8;
  localparam int LimitCycles  = 400000;
  localparam logic ModePlanar     = 1'b0;
  localparam logic ModeQuaternion = 1'b1;

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [AddrW-1:0]    paddr   = '0;
  logic [DataW-1:0]    pwdata  = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req_data  = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_t                res_data;

  // register shadows, reset values
  logic [8:0]  cfg_dim    = 9'd256;
  logic [2:0]  cfg_bits   = 3'd4;
  logic        cfg_mode   = ModePlanar;
  logic        cfg_rot_en = 1'b0;
  logic [15:0] cfg_scale  = 16'd4096;

  logic [63:0] rot_words [64];
  bit          loaded [64];
  req_t        req_backlog [$];
  res_t        expected_codes [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done  = 1'b0;
  int          hold_cnt   = 0;

  rotated_vector_quantizer_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always #HalfPeriod clk = ~clk;

  function automatic int centroid_q12(input int idx);
    case (idx)
      0: return 3268;
      1: return 1855;
      2: return 6185;
      3: return 1004;
      4: return 3097;
      5: return 5505;
      6: return 8815;
      7: return 526;
      8: return 1589;
      9: return 2690;
      10: return 3860;
      11: return 5145;
      12: return 6627;
      13: return 8475;
      default: return 11193;
    endcase
  endfunction

  function automatic logic [3:0] nearest_centroid(input int v, input int bits);
    int half, off, best, min_err, m, c, d;
    half = 1 << (bits - 1);
    off = half - 1;
    best = 0;
    min_err = -1;
    for (int i = 0; i < 2 * half; i++) begin
      m = (i < half) ? centroid_q12(off + half - 1 - i) : centroid_q12(off + i - half);
      m = (m * int'(cfg_scale)) >> 16;
      c = (i < half) ? -m : m;
      d = v - c;
      if (d < 0) d = -d;
      if (min_err < 0 || d < min_err) begin
        min_err = d;
        best = i;
      end
    end
    return best[3:0];
  endfunction

  // Q3.12 x Q1.14 sum back to Q3.12: floor shift, then saturate
  function automatic int q14_to_q12(input longint s);
    longint q;
    q = s >>> 14;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic bit predict_codes(input req_t r, output res_t res);
    int     dim, bits, base, lanes;
    longint a [4];
    longint b [4];
    int     y [4];
    logic [63:0] w;
    res = '0;
    dim = (cfg_dim == 0) ? 1 : (cfg_dim > MaxDim) ? MaxDim : int'(cfg_dim);
    bits = (cfg_bits == 0) ? 1 : (cfg_bits > 4) ? 4 : int'(cfg_bits);
    base = int'(r.chunk_index) * 4;
    if (base >= dim) return 1'b0;
    lanes = (dim - base > 4) ? 4 : dim - base;
    b[0] = $signed(r.elem_0);
    b[1] = (lanes > 1) ? longint'($signed(r.elem_1)) : 0;
    b[2] = (lanes > 2) ? longint'($signed(r.elem_2)) : 0;
    b[3] = (lanes > 3) ? longint'($signed(r.elem_3)) : 0;
    if (cfg_rot_en) begin
      w = rot_words[r.chunk_index];
      a[0] = $signed(w[15:0]);
      a[1] = $signed(w[31:16]);
      a[2] = $signed(w[47:32]);
      a[3] = $signed(w[63:48]);
      if (cfg_mode == ModePlanar) begin
        y[0] = q14_to_q12(a[0] * b[0] - a[1] * b[1]);
        y[1] = q14_to_q12(a[1] * b[0] + a[0] * b[1]);
        y[2] = q14_to_q12(a[2] * b[2] - a[3] * b[3]);
        y[3] = q14_to_q12(a[3] * b[2] + a[2] * b[3]);
      end else begin
        y[0] = q14_to_q12(a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3]);
        y[1] = q14_to_q12(a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2]);
        y[2] = q14_to_q12(a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1]);
        y[3] = q14_to_q12(a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0]);
      end
    end else begin
      for (int j = 0; j < 4; j++) y[j] = int'(b[j]);
    end
    res.chunk_out = r.chunk_index;
    res.code_0 = nearest_centroid(y[0], bits);
    res.code_1 = (lanes > 1) ? nearest_centroid(y[1], bits) : 4'd0;
    res.code_2 = (lanes > 2) ? nearest_centroid(y[2], bits) : 4'd0;
    res.code_3 = (lanes > 3) ? nearest_centroid(y[3], bits) : 4'd0;
    res.valid_lanes = lanes[2:0];
    return 1'b1;
  endfunction

  task automatic record_request(input req_t r);
    res_t res;
    if (r.command == CmdLoad) begin
      rot_words[r.chunk_index] = {r.rot_3, r.rot_2, r.rot_1, r.rot_0};
    end else if (predict_codes(r, res)) begin
      expected_codes.push_back(res);
    end
  endtask

  // request driver and predictor hook
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) record_request(req_data);
      if (!req_valid || !req_stall) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req_data <= req_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      res_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HoldCycles - 1) hold_done <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_codes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: chunk %0d codes %0d %0d %0d %0d lanes %0d",
                   res_data.chunk_out, res_data.code_0, res_data.code_1,
                   res_data.code_2, res_data.code_3, res_data.valid_lanes);
        mismatches++;
      end else begin
        want = expected_codes.pop_front();
        if (res_data !== want) begin
          if (mismatches < 10) begin
            $display("mismatch: exp chunk %0d codes %0d %0d %0d %0d lanes %0d",
                     want.chunk_out, want.code_0, want.code_1, want.code_2,
                     want.code_3, want.valid_lanes);
            $display("          got chunk %0d codes %0d %0d %0d %0d lanes %0d",
                     res_data.chunk_out, res_data.code_0, res_data.code_1,
                     res_data.code_2, res_data.code_3, res_data.valid_lanes);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDimension:     cfg_dim = value[8:0];
      RegBitDepth:      cfg_bits = value[2:0];
      RegRotationMode:  cfg_mode = value[0];
      RegRotateEnable:  cfg_rot_en = value[0];
      RegCentroidScale: cfg_scale = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int dim, input int bits, input int mode,
                            input int rot_en, input int scale);
    write_reg(RegDimension, dim);
    write_reg(RegBitDepth, bits);
    write_reg(RegRotationMode, mode);
    write_reg(RegRotateEnable, rot_en);
    write_reg(RegCentroidScale, scale);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // all requests taken, all results back, pipeline flushed
  task automatic drain();
    while (req_backlog.size() != 0 || req_valid) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem();
    int x;
    case ($urandom_range(9))
      0: x = -32768;
      1: x = 32767;
      2, 3: x = int'($urandom_range(65535));
      default: x = int'($urandom_range(24000)) - 12000;
    endcase
    return x[15:0];
  endfunction

  function automatic logic signed [15:0] rand_rot();
    int x;
    case ($urandom_range(7))
      0: x = 16384;
      1: x = -16384;
      2: x = 0;
      default: x = int'($urandom_range(32768)) - 16384;
    endcase
    return x[15:0];
  endfunction

  task automatic queue_load(input int chunk, input int r0, input int r1,
                            input int r2, input int r3);
    req_t r;
    r.command = CmdLoad;
    r.chunk_index = chunk[5:0];
    r.elem_0 = rand_elem();
    r.elem_1 = rand_elem();
    r.elem_2 = rand_elem();
    r.elem_3 = rand_elem();
    r.rot_0 = r0[15:0];
    r.rot_1 = r1[15:0];
    r.rot_2 = r2[15:0];
    r.rot_3 = r3[15:0];
    loaded[chunk] = 1'b1;
    req_backlog.push_back(r);
  endtask

  task automatic queue_quantize(input int chunk, input int e0, input int e1,
                                input int e2, input int e3);
    req_t r;
    if (cfg_rot_en && !loaded[chunk])
      queue_load(chunk, rand_rot(), rand_rot(), rand_rot(), rand_rot());
    r.command = CmdQuantize;
    r.chunk_index = chunk[5:0];
    r.elem_0 = e0[15:0];
    r.elem_1 = e1[15:0];
    r.elem_2 = e2[15:0];
    r.elem_3 = e3[15:0];
    r.rot_0 = rand_rot();
    r.rot_1 = rand_rot();
    r.rot_2 = rand_rot();
    r.rot_3 = rand_rot();
    req_backlog.push_back(r);
  endtask

  task automatic queue_random(input int count);
    int dim_eff, used, chunk;
    dim_eff = (cfg_dim == 0) ? 1 : (cfg_dim > MaxDim) ? MaxDim : int'(cfg_dim);
    used = (dim_eff + 3) / 4;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 15) begin
        queue_load($urandom_range(63), rand_rot(), rand_rot(), rand_rot(), rand_rot());
      end else begin
        chunk = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(used - 1);
        queue_quantize(chunk, rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(22, 48);

    // plain quantize, loads
    set_config(256, 4, ModePlanar, 0, 4096);
    queue_quantize(0, 32767, -32768, 0, -1);
    queue_quantize(63, 1, -1, 16384, -16384);
    queue_load(5, 16384, 0, 16384, 0);
    queue_load(6, -16384, 16384, 11585, -11585);
    queue_load(7, 8192, 8192, 8192, 8192);
    queue_load(8, 16384, 16384, -16384, -16384);
    drain();

    // planar rotation, saturation
    write_reg(RegRotateEnable, 1);
    queue_quantize(5, 32767, -32768, 12345, -1);
    queue_quantize(6, -32768, -32768, 32767, 32767);
    queue_quantize(8, 32767, 32767, -32768, -32768);
    drain();

    // quaternion rotation
    write_reg(RegRotationMode, ModeQuaternion);
    queue_quantize(7, 32767, -32768, 32767, -32768);
    queue_quantize(8, -32768, -32768, -32768, -32768);
    drain();

    // partial chunk and chunks past the dimension
    write_reg(RegDimension, 6);
    queue_quantize(0, 4000, -4000, 100, -100);
    queue_quantize(1, 9000, -9000, 5000, 5000);
    queue_quantize(2, 1, 2, 3, 4);
    queue_quantize(63, 1, 2, 3, 4);
    drain();

    // zero dimension and zero depth clamp up
    set_config(0, 0, ModePlanar, 0, 65535);
    queue_quantize(0, 100, -200, 300, -400);
    queue_quantize(1, 100, -200, 300, -400);
    drain();

    // oversize dimension and depth clamp down; zero scale makes every centroid tie
    set_config(511, 7, ModePlanar, 0, 0);
    queue_quantize(63, 32767, -32768, 5, -5);
    queue_quantize(0, -1, 0, 1, 2);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p < 3) set_idling(22, 48);
      else if (p < 6) set_idling(48, 22);
      else set_idling(0, 0);
      case (p)
        0: set_config(256, 4, ModePlanar, 1, 4096);
        1: set_config(100, 3, ModeQuaternion, 1, 8192);
        2: set_config(1, 1, ModePlanar, 1, 65535);
        3: set_config(511, 5, ModeQuaternion, 1, $urandom_range(65535));
        4: set_config(0, 0, ModePlanar, 0, $urandom_range(65535));
        5: set_config(37, 2, ModePlanar, 1, 30000);
        6: set_config(256, 6, ModeQuaternion, 1, 2048);
        default: set_config($urandom_range(1, 256), $urandom_range(1, 4),
                            $urandom_range(1), 1, $urandom_range(65535));
      endcase
      queue_random(PhaseItems);
      if (p == 1) hold_armed <= 1'b1;
      drain();
    end

    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(2 * HalfPeriod * LimitCycles);
    $display("tb: failure");
    $finish;
  end

endmodule

/* rotated_vector_quantizer_core.f */
rtl/rvq_pkg.sv
rtl/rotated_vector_quantizer_core.sv
rtl/rvq_checker.sv
test/tb_rotated_vector_quantizer_core.sv
